// ----- src/cscan_pkg.sv -----
// ============================================================================
// cscan_pkg
// Shared widths, constants and state encoding for the C-SCAN disk scheduler.
// ============================================================================
package cscan_pkg;

    localparam int TRK_W             = 16;
    localparam int SEEK_W            = 18;
    localparam int IN_TDATA_W        = 40;
    localparam int OUT_TDATA_W       = 40;
    localparam int DEF_MAX_REQUESTS  = 16;

    localparam logic [SEEK_W-1:0] SEEK_MAX       = 18'h3FFFF;
    localparam logic [TRK_W-1:0]  LAST_TRACK_RST = 16'd199;

    typedef enum logic [2:0] {
        S_LOAD,
        S_COUNT,
        S_PINIT,
        S_PASS,
        S_EMIT
    } t_state;

endpackage

// ----- src/cscan_disk_scheduler.sv -----
// ============================================================================
// cscan_disk_scheduler
// C-SCAN disk scheduler with a stream input of requests and a stream output
// of the service order.
// ============================================================================
// Requests are taken one beat per cycle and written to the request store,
// which has one write and one read port; the beat with tlast closes the batch
// and supplies head and direction. Intake then stops while the batch is
// scheduled: one counting pass sizes the lower and upper sets, and each
// output track costs one scan over the n stored requests (at most
// MAX_REQUESTS), because the store's one read port is swept once per emitted
// track. A batch of n requests emits up to n + 2 tracks. The final output
// beat carries tlast and the saturated total seek distance.
module cscan_disk_scheduler #(
    parameter int MAX_REQUESTS = cscan_pkg::DEF_MAX_REQUESTS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration: last_track
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cscan_pkg::TRK_W-1:0]       i_cfg_data,
    // Request stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] track, [31:16] head, [32] direction, [39:33] zero
    input  logic [cscan_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                              s_axis_tlast,
    // Service order stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [15:0] seek_track, [33:16] total_seek, [39:34] zero
    output logic [cscan_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                              m_axis_tlast
);

    localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam int TW = cscan_pkg::TRK_W;
    localparam int SW = cscan_pkg::SEEK_W;

    logic [TW-1:0] r_last_track;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [TW-1:0] mem_wdata, mem_rdata;
    logic [TW-1:0] out_track;
    logic [SW-1:0] out_total;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_track <= cscan_pkg::LAST_TRACK_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_last_track <= i_cfg_data;
        end
    end

    cscan_mem #(
        .DEPTH (MAX_REQUESTS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    cscan_seq #(
        .MAX_REQUESTS (MAX_REQUESTS),
        .AW           (AW),
        .CW           (CW)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_last_track (r_last_track),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_track      (s_axis_tdata[15:0]),
        .i_head       (s_axis_tdata[31:16]),
        .i_dir        (s_axis_tdata[32]),
        .i_last       (s_axis_tlast),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_seek_track (out_track),
        .o_total_seek (out_total),
        .o_last_res   (m_axis_tlast),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata)
    );

    assign m_axis_tdata = {6'b0, out_total, out_track};

endmodule

// ----- src/cscan_mem.sv -----
// ============================================================================
// cscan_mem
// Request store: one write port, one read port, registered read data.
// ============================================================================
module cscan_mem #(
    parameter int DEPTH = cscan_pkg::DEF_MAX_REQUESTS,
    parameter int AW    = 4
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [cscan_pkg::TRK_W-1:0] i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [cscan_pkg::TRK_W-1:0] o_rdata
);

    logic [cscan_pkg::TRK_W-1:0] r_mem [DEPTH];
    logic [cscan_pkg::TRK_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/cscan_seq.sv -----
// ============================================================================
// cscan_seq
// Batch intake and scheduling sequencer. Each output track is found by one
// scan of the request store that picks the next key in sweep order.
// ============================================================================
module cscan_seq #(
    parameter int MAX_REQUESTS = cscan_pkg::DEF_MAX_REQUESTS,
    parameter int AW           = 4,
    parameter int CW           = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [cscan_pkg::TRK_W-1:0]  i_last_track,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [cscan_pkg::TRK_W-1:0]  i_track,
    input  logic [cscan_pkg::TRK_W-1:0]  i_head,
    input  logic                         i_dir,
    input  logic                         i_last,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [cscan_pkg::TRK_W-1:0]  o_seek_track,
    output logic [cscan_pkg::SEEK_W-1:0] o_total_seek,
    output logic                         o_last_res,
    output logic                         o_mem_we,
    output logic [AW-1:0]                o_mem_waddr,
    output logic [cscan_pkg::TRK_W-1:0]  o_mem_wdata,
    output logic [AW-1:0]                o_mem_raddr,
    input  logic [cscan_pkg::TRK_W-1:0]  i_mem_rdata
);

    localparam int TW = cscan_pkg::TRK_W;
    localparam int SW = cscan_pkg::SEEK_W;
    localparam int KW = TW + CW;
    localparam logic [CW-1:0] VIRT_IDX = CW'(MAX_REQUESTS);

    cscan_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_scan_addr, n_scan_addr;
    logic          r_rd_vld;
    logic [CW-1:0] r_rd_idx;
    logic [CW-1:0] r_nlo, n_nlo;
    logic [CW-1:0] r_nhi, n_nhi;
    logic [TW-1:0] r_head, n_head;
    logic          r_dir, n_dir;
    logic          r_phase, n_phase;
    logic [CW:0]   r_cnt_ph, n_cnt_ph;
    logic [CW:0]   r_need, n_need;
    logic          r_first, n_first;
    logic [KW-1:0] r_prev, n_prev;
    logic          r_found, n_found;
    logic [KW-1:0] r_best, n_best;
    logic [TW-1:0] r_pos, n_pos;
    logic [SW-1:0] r_acc, n_acc;

    logic          r_out_valid, n_out_valid;
    logic [TW-1:0] r_out_track, n_out_track;
    logic [SW-1:0] r_out_total, n_out_total;
    logic          r_out_last, n_out_last;

    logic          accept, store, issue, scan_done, emit_go;
    logic          sel_hi, asc, is_lo, is_hi, member, elig, better;
    logic          v_elig, phase_end, final_item;
    logic [KW-1:0] rd_key, v_key;
    logic [TW-1:0] v_val, best_val, seek_dist;
    logic [SW:0]   sum;
    logic [SW-1:0] acc_new;

    // Set selection for the current phase and sweep.
    assign sel_hi = ~(r_dir ^ r_phase);
    assign asc    = ~r_dir;

    assign accept    = i_in_valid && o_in_ready;
    assign store     = accept && (r_count < CW'(MAX_REQUESTS));
    assign issue     = ((r_state == cscan_pkg::S_COUNT) || (r_state == cscan_pkg::S_PASS))
                       && (r_scan_addr < r_count);
    assign scan_done = (r_scan_addr == r_count) && !r_rd_vld;
    assign emit_go   = (r_state == cscan_pkg::S_EMIT) && (!r_out_valid || i_out_ready);

    assign rd_key = {i_mem_rdata, r_rd_idx};
    assign is_lo  = i_mem_rdata < r_head;
    assign is_hi  = i_mem_rdata > r_head;
    assign member = sel_hi ? is_hi : is_lo;
    assign elig   = member && (r_first || (asc ? (rd_key > r_prev) : (rd_key < r_prev)));
    assign better = !r_found || (asc ? (rd_key < r_best) : (rd_key > r_best));

    // Track 0 joins the lower set and last_track the upper set as an extra entry.
    assign v_val  = sel_hi ? i_last_track : '0;
    assign v_key  = {v_val, VIRT_IDX};
    assign v_elig = r_first || (asc ? (v_key > r_prev) : (v_key < r_prev));

    assign best_val   = r_best[KW-1:CW];
    assign seek_dist  = (best_val > r_pos) ? (best_val - r_pos) : (r_pos - best_val);
    assign sum        = {1'b0, r_acc} + (SW+1)'(seek_dist);
    assign acc_new    = sum[SW] ? cscan_pkg::SEEK_MAX : sum[SW-1:0];
    assign phase_end  = (r_cnt_ph + (CW+1)'(1)) == r_need;
    assign final_item = r_phase && phase_end;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            cscan_pkg::S_LOAD: begin
                if (accept && i_last) begin
                    n_state = cscan_pkg::S_COUNT;
                end
            end
            cscan_pkg::S_COUNT: begin
                if (scan_done) begin
                    n_state = cscan_pkg::S_PINIT;
                end
            end
            cscan_pkg::S_PINIT: begin
                n_state = cscan_pkg::S_PASS;
            end
            cscan_pkg::S_PASS: begin
                if (scan_done) begin
                    n_state = cscan_pkg::S_EMIT;
                end
            end
            cscan_pkg::S_EMIT: begin
                if (emit_go) begin
                    n_state = final_item ? cscan_pkg::S_LOAD : cscan_pkg::S_PINIT;
                end
            end
            default: begin
                n_state = cscan_pkg::S_LOAD;
            end
        endcase
    end

    // Datapath and output register.
    always_comb begin
        n_count     = r_count;
        n_scan_addr = issue ? (r_scan_addr + CW'(1)) : r_scan_addr;
        n_nlo       = r_nlo;
        n_nhi       = r_nhi;
        n_head      = r_head;
        n_dir       = r_dir;
        n_phase     = r_phase;
        n_cnt_ph    = r_cnt_ph;
        n_need      = r_need;
        n_first     = r_first;
        n_prev      = r_prev;
        n_found     = r_found;
        n_best      = r_best;
        n_pos       = r_pos;
        n_acc       = r_acc;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_track = r_out_track;
        n_out_total = r_out_total;
        n_out_last  = r_out_last;

        case (r_state)
            cscan_pkg::S_LOAD: begin
                if (store) begin
                    n_count = r_count + CW'(1);
                end
                if (accept && i_last) begin
                    n_head      = i_head;
                    n_dir       = i_dir;
                    n_nlo       = '0;
                    n_nhi       = '0;
                    n_scan_addr = '0;
                end
            end
            cscan_pkg::S_COUNT: begin
                if (r_rd_vld && is_lo) begin
                    n_nlo = r_nlo + CW'(1);
                end
                if (r_rd_vld && is_hi) begin
                    n_nhi = r_nhi + CW'(1);
                end
                if (scan_done) begin
                    n_phase  = 1'b0;
                    n_cnt_ph = '0;
                    n_need   = {1'b0, (r_dir ? r_nlo : r_nhi)} + (CW+1)'(1);
                    n_first  = 1'b1;
                    n_pos    = r_head;
                    n_acc    = SW'(i_last_track);
                end
            end
            cscan_pkg::S_PINIT: begin
                n_scan_addr = '0;
                n_found     = v_elig;
                n_best      = v_key;
            end
            cscan_pkg::S_PASS: begin
                if (r_rd_vld && elig && better) begin
                    n_found = 1'b1;
                    n_best  = rd_key;
                end
            end
            cscan_pkg::S_EMIT: begin
                if (emit_go) begin
                    n_out_valid = 1'b1;
                    n_out_track = best_val;
                    n_out_total = final_item ? acc_new : '0;
                    n_out_last  = final_item;
                    n_acc       = acc_new;
                    n_pos       = best_val;
                    n_prev      = r_best;
                    n_first     = 1'b0;
                    n_cnt_ph    = r_cnt_ph + (CW+1)'(1);
                    if (final_item) begin
                        n_count = '0;
                    end else if (phase_end) begin
                        // Jump to the opposite end of the disk and start the second set.
                        n_phase  = 1'b1;
                        n_cnt_ph = '0;
                        n_need   = {1'b0, (r_dir ? r_nhi : r_nlo)} + (CW+1)'(1);
                        n_first  = 1'b1;
                        n_pos    = r_dir ? i_last_track : '0;
                    end
                end
            end
            default: begin
                n_count = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cscan_pkg::S_LOAD;
            r_count     <= '0;
            r_scan_addr <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_scan_addr <= n_scan_addr;
            r_rd_vld    <= issue;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx    <= r_scan_addr;
        r_nlo       <= n_nlo;
        r_nhi       <= n_nhi;
        r_head      <= n_head;
        r_dir       <= n_dir;
        r_phase     <= n_phase;
        r_cnt_ph    <= n_cnt_ph;
        r_need      <= n_need;
        r_first     <= n_first;
        r_prev      <= n_prev;
        r_found     <= n_found;
        r_best      <= n_best;
        r_pos       <= n_pos;
        r_acc       <= n_acc;
        r_out_track <= n_out_track;
        r_out_total <= n_out_total;
        r_out_last  <= n_out_last;
    end

    assign o_in_ready   = (r_state == cscan_pkg::S_LOAD);
    assign o_out_valid  = r_out_valid;
    assign o_seek_track = r_out_track;
    assign o_total_seek = r_out_total;
    assign o_last_res   = r_out_last;
    assign o_mem_we     = store;
    assign o_mem_waddr  = r_count[AW-1:0];
    assign o_mem_wdata  = i_track;
    assign o_mem_raddr  = r_scan_addr[AW-1:0];

    // Every selection pass must find an entry, since the counting pass sized the sets.
    a_emit_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cscan_pkg::S_EMIT) |-> r_found)
        else $error("selection pass ended without a candidate");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_REQUESTS))
        else $error("request count beyond store depth");

    a_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cscan_pkg::S_PINIT) |->
        (({1'b0, r_nlo} + {1'b0, r_nhi}) <= {1'b0, r_count}))
        else $error("set sizes exceed stored requests");

    a_phase_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cscan_pkg::S_PASS) |-> (r_cnt_ph < r_need))
        else $error("phase emitted more tracks than its set holds");

    a_batch_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_go && final_item) |=> (r_count == '0 && r_state == cscan_pkg::S_LOAD))
        else $error("batch not cleared after final track");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for the C-SCAN disk scheduler. Request batches are
// driven on the input stream. A local scheduling model works out the service
// order and total seek distance of each closed batch, and every output beat
// is compared with it. The last_track register is changed between phases.
// ============================================================================
module testbench;

    typedef enum logic {
        SWEEP_UP   = 1'b0,
        SWEEP_DOWN = 1'b1
    } t_sweep;

    typedef logic [cscan_pkg::TRK_W-1:0]  t_track;
    typedef logic [cscan_pkg::SEEK_W-1:0] t_seek;

    typedef struct packed {
        t_track track;
        t_track head;
        t_sweep dir;
        logic   fin;
    } t_disk_req;

    typedef struct packed {
        t_track track;
        t_seek  total;
        logic   fin;
    } t_service_beat;

    localparam int IDLE_PCT   = 9;
    localparam int DRAIN_WAIT = 30;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    t_track                            i_cfg_data = '0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [cscan_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                              s_axis_tlast = 1'b0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [cscan_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                              m_axis_tlast;

    // Model state: the disk size register and the current batch.
    t_track      disk_last = cscan_pkg::LAST_TRACK_RST;
    t_track      batch_tracks [cscan_pkg::DEF_MAX_REQUESTS];
    int unsigned batch_len = 0;

    t_disk_req     pending_reqs [$];
    t_service_beat service_order [$];
    t_disk_req     req_on_bus;
    bit            req_taken = 1'b0;
    bit            no_gaps = 1'b0;
    int unsigned   mismatches = 0;

    cscan_disk_scheduler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned track_gap(int unsigned a, int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Stores one request; a closing request schedules the batch and queues
    // the expected service order.
    function automatic void take_request(t_disk_req r);
        int unsigned   lower [$];
        int unsigned   upper [$];
        int unsigned   order [$];
        int unsigned   pos;
        int unsigned   total;
        t_service_beat beat;
        if (batch_len < cscan_pkg::DEF_MAX_REQUESTS) begin
            batch_tracks[batch_len] = r.track;
            batch_len++;
        end
        if (!r.fin)
            return;
        // Both disk ends always take part in the sweep.
        lower.push_back(32'd0);
        upper.push_back(32'(disk_last));
        for (int i = 0; i < batch_len; i++) begin
            if (batch_tracks[i] < r.head)
                lower.push_back(32'(batch_tracks[i]));
            else if (batch_tracks[i] > r.head)
                upper.push_back(32'(batch_tracks[i]));
        end
        lower.sort();
        upper.sort();
        total = 0;
        pos = 32'(r.head);
        if (r.dir == SWEEP_UP) begin
            foreach (upper[i]) begin
                total += track_gap(upper[i], pos);
                pos = upper[i];
                order.push_back(upper[i]);
            end
            total += 32'(disk_last);
            pos = 32'd0;
            foreach (lower[i]) begin
                total += track_gap(lower[i], pos);
                pos = lower[i];
                order.push_back(lower[i]);
            end
        end else begin
            for (int i = lower.size() - 1; i >= 0; i--) begin
                total += track_gap(lower[i], pos);
                pos = lower[i];
                order.push_back(lower[i]);
            end
            total += 32'(disk_last);
            pos = 32'(disk_last);
            for (int i = upper.size() - 1; i >= 0; i--) begin
                total += track_gap(upper[i], pos);
                pos = upper[i];
                order.push_back(upper[i]);
            end
        end
        if (total > 32'(cscan_pkg::SEEK_MAX))
            total = 32'(cscan_pkg::SEEK_MAX);
        foreach (order[k]) begin
            beat.track = t_track'(order[k]);
            beat.fin   = (k == order.size() - 1);
            beat.total = beat.fin ? t_seek'(total) : '0;
            service_order.push_back(beat);
        end
        batch_len = 0;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        mismatches++;
        $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // Request driver: holds a beat until it is taken, with random gaps unless no_gaps is set.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            take_request(req_on_bus);
            req_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || req_taken)) begin
            req_taken = 1'b0;
            if (pending_reqs.size() > 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
                req_on_bus = pending_reqs.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {7'b0, req_on_bus.dir, req_on_bus.head, req_on_bus.track};
                s_axis_tlast  <= req_on_bus.fin;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output side: random back-pressure unless no_gaps is set, and a check of every accepted beat.
    always @(negedge i_clk) begin
        if (i_rst_n)
            m_axis_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        t_service_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (service_order.size() == 0) begin
                report_mismatch("unexpected beat, seek_track", 32'(m_axis_tdata[15:0]), 0);
            end else begin
                want = service_order.pop_front();
                if (m_axis_tdata[15:0] !== want.track)
                    report_mismatch("seek_track", 32'(m_axis_tdata[15:0]), 32'(want.track));
                if (m_axis_tdata[33:16] !== want.total)
                    report_mismatch("total_seek", 32'(m_axis_tdata[33:16]), 32'(want.total));
                if (m_axis_tlast !== want.fin)
                    report_mismatch("last_res", 32'(m_axis_tlast), 32'(want.fin));
            end
        end
    end

    task automatic push_req(t_track track, t_track head, t_sweep dir, logic fin);
        t_disk_req r;
        r.track = track;
        r.head  = head;
        r.dir   = dir;
        r.fin   = fin;
        pending_reqs.push_back(r);
    endtask

    function automatic t_track pick_track(t_track head);
        case ($urandom_range(11))
            0:       return '0;
            1:       return '1;
            2:       return head;
            3:       return disk_last;
            4, 5:    return t_track'($urandom);
            6:       return t_track'(32'(head) + $urandom_range(4) - 32'd2);
            default: return t_track'($urandom_range(32'(disk_last)));
        endcase
    endfunction

    // Queues one random batch and returns its number of requests.
    task automatic queue_random_batch(output int unsigned n);
        int unsigned size_pick;
        t_track      head;
        t_sweep      dir;
        size_pick = $urandom_range(99);
        if (size_pick < 70)
            n = $urandom_range(6, 1);
        else if (size_pick < 92)
            n = $urandom_range(cscan_pkg::DEF_MAX_REQUESTS, 7);
        else
            n = $urandom_range(cscan_pkg::DEF_MAX_REQUESTS + 4,
                               cscan_pkg::DEF_MAX_REQUESTS + 1);
        case ($urandom_range(9))
            0:       head = '0;
            1:       head = '1;
            2:       head = disk_last;
            3:       head = t_track'($urandom);
            default: head = t_track'($urandom_range(32'(disk_last)));
        endcase
        dir = t_sweep'($urandom_range(1));
        // Head and direction on the earlier beats are ignored by the block.
        for (int i = 1; i < n; i++)
            push_req(pick_track(head), t_track'($urandom), t_sweep'($urandom_range(1)), 1'b0);
        push_req(pick_track(head), head, dir, 1'b1);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || s_axis_tvalid || service_order.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_last_track(t_track value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        disk_last = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned phase_items;
        int unsigned n;
        t_track      cfg_value;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed batches with the reset disk size.
        push_req(16'd0, 16'd0, SWEEP_UP, 1'b0);
        push_req(16'hFFFF, 16'd0, SWEEP_UP, 1'b0);
        push_req(16'd100, 16'd0, SWEEP_UP, 1'b0);
        push_req(16'd37, 16'd0, SWEEP_UP, 1'b0);
        push_req(16'd150, 16'd100, SWEEP_UP, 1'b1);
        // A batch of one request.
        push_req(16'h8000, 16'hFFFF, SWEEP_DOWN, 1'b1);
        // Tracks beyond the disk end are scheduled as they are.
        push_req(16'd300, 16'd0, SWEEP_UP, 1'b0);
        push_req(16'd199, 16'd0, SWEEP_UP, 1'b0);
        push_req(16'd5, 16'd0, SWEEP_DOWN, 1'b1);
        // Only request sits on the head and is dropped.
        push_req(16'd0, 16'd0, SWEEP_UP, 1'b1);
        push_req(16'hAAAA, 16'h5555, SWEEP_DOWN, 1'b0);
        push_req(16'h5555, 16'hAAAA, SWEEP_DOWN, 1'b0);
        push_req(16'd12, 16'hFFFF, SWEEP_UP, 1'b1);
        // Duplicate tracks, one of them equal to the disk end.
        push_req(16'd7, 16'd0, SWEEP_UP, 1'b0);
        push_req(16'd7, 16'd0, SWEEP_UP, 1'b0);
        push_req(16'd199, 16'd0, SWEEP_UP, 1'b0);
        push_req(16'd0, 16'd7, SWEEP_DOWN, 1'b1);
        wait_drained();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       cfg_value = 16'd1;
                1:       cfg_value = 16'hFFFF;
                5:       cfg_value = cscan_pkg::LAST_TRACK_RST;
                default: cfg_value = t_track'($urandom_range(32'hFFFF, 1));
            endcase
            write_last_track(cfg_value);
            no_gaps = (phase == 2);
            phase_items = 0;
            while (phase_items < 67) begin
                queue_random_batch(n);
                phase_items += n;
            end
            wait_drained();
        end

        if (mismatches == 0)
            $display("cscan_disk_scheduler: match");
        else
            $display("cscan_disk_scheduler: mismatch");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("cscan_disk_scheduler: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/cscan_pkg.sv
src/cscan_mem.sv
src/cscan_seq.sv
src/cscan_disk_scheduler.sv
tb/sv/testbench.sv
